/* hdl/capr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package capr_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FRAME_W     = 7;
  localparam int CNT_W       = IDX_W + 1;

  // input item kinds
  localparam logic [1:0] MODE_FILL   = 2'd0;
  localparam logic [1:0] MODE_TOUCH  = 2'd1;
  localparam logic [1:0] MODE_VICTIM = 2'd2;

  // register map (word index)
  localparam logic REG_ENTRIES_IN_USE = 1'b0;

  localparam logic [CNT_W-1:0] ENTRIES_RESET = CNT_W'(TABLE_DEPTH);

  // table word without the valid bit, which lives in flops
  typedef struct packed {
    logic               used;
    logic               modified;
    logic               dirty;
    logic [FRAME_W-1:0] frame;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/clock_aging_page_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    | handshake                 | payload
// -----------+---------------------------+-------------------------------------------------
// input      | in_valid / in_ready       | mode, entry_index, frame_number, is_write
// output     | out_valid / out_ready     | victim_found, victim_index, evicted_frame, victim_dirty
// config     | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// one transaction in flight at a time; each input transaction gives one output transaction
// fill and unknown modes answer from the idle state; touch does one table read, then one write back
// a victim search takes a start step and then, per entry visited, the table read (S_SW_RD)
// followed by the decision (S_SW_EV); with no valid entry it visits every one of the
// swept entries
// rst is synchronous: table valid flops cleared, hand at zero, entries_in_use at 256
// a stalled output holds its register; the next input is taken as the output drains

module clock_aging_page_replacement
  import capr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [IDX_W-1:0]   entry_index,
  input  wire logic [FRAME_W-1:0] frame_number,
  input  wire logic               is_write,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    victim_found,
  output logic [IDX_W-1:0]        victim_index,
  output logic [FRAME_W-1:0]      evicted_frame,
  output logic                    victim_dirty,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TOUCH = 2'd1;
  localparam logic [1:0] S_SW_RD = 2'd2;
  localparam logic [1:0] S_SW_EV = 2'd3;

  logic [1:0]         state, state_next;
  logic [CNT_W-1:0]   entries_in_use;
  logic [CNT_W-1:0]   swept;
  logic [IDX_W-1:0]   hand, hand_next;
  logic [IDX_W-1:0]   pos, pos_next, pos_inc;
  logic [IDX_W-1:0]   cnt, cnt_next;
  logic               seen, seen_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               wr, wr_next;

  // table: payload bits in a synchronous ram, valid bits in flops
  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  entry_t             mem_wdata;
  logic [TABLE_DEPTH-1:0] valid;
  logic               vld_set, vld_clr;
  logic [IDX_W-1:0]   vld_addr;

  entry_t             cur;
  logic               res_load, res_found, res_dirty;
  logic [IDX_W-1:0]   res_index;
  logic [FRAME_W-1:0] res_frame;
  logic               cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENTRIES_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= ENTRIES_RESET;
    end else if (cfg_wr) begin
      entries_in_use <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ENTRIES_IN_USE) begin
      prdata = {{(32-CNT_W){1'b0}}, entries_in_use};
    end
  end

  // zero behaves as one, anything past the table as the full table
  always_comb begin
    if (entries_in_use == '0) begin
      swept = CNT_W'(1);
    end else if (entries_in_use > CNT_W'(TABLE_DEPTH)) begin
      swept = CNT_W'(TABLE_DEPTH);
    end else begin
      swept = entries_in_use;
    end
  end

  assign pos_inc = (({1'b0, pos} + CNT_W'(1)) >= swept) ? '0 : pos + IDX_W'(1);

  // table ram: one read, one write per cycle
  assign rd_addr = (state == S_IDLE) ? entry_index : ((state == S_TOUCH) ? idx : pos);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (vld_set) valid[vld_addr] <= 1'b1;
      if (vld_clr) valid[vld_addr] <= 1'b0;
    end
  end

  // an invalid entry always reads as all zero
  always_comb begin
    cur = '0;
    if (state == S_TOUCH) begin
      if (valid[idx]) cur = rd_data;
    end else begin
      if (valid[pos]) cur = rd_data;
    end
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    hand_next  = hand;
    pos_next   = pos;
    cnt_next   = cnt;
    seen_next  = seen;
    idx_next   = idx;
    wr_next    = wr;
    mem_we     = 1'b0;
    mem_waddr  = pos;
    mem_wdata  = '0;
    vld_set    = 1'b0;
    vld_clr    = 1'b0;
    vld_addr   = pos;
    res_load   = 1'b0;
    res_found  = 1'b0;
    res_index  = '0;
    res_frame  = '0;
    res_dirty  = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          idx_next = entry_index;
          wr_next  = is_write;
          unique case (mode)
            MODE_FILL: begin
              mem_we          = 1'b1;
              mem_waddr       = entry_index;
              mem_wdata.used  = 1'b1;
              mem_wdata.frame = frame_number;
              vld_set         = 1'b1;
              vld_addr        = entry_index;
              res_load        = 1'b1;
            end
            MODE_TOUCH: begin
              state_next = S_TOUCH;
            end
            MODE_VICTIM: begin
              pos_next   = ({1'b0, hand} < swept) ? hand : '0;
              cnt_next   = '0;
              seen_next  = 1'b0;
              state_next = S_SW_RD;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_TOUCH: begin
        mem_we         = 1'b1;
        mem_waddr      = idx;
        mem_wdata      = cur;
        mem_wdata.used = 1'b1;
        if (wr) begin
          mem_wdata.dirty    = 1'b1;
          mem_wdata.modified = 1'b1;
        end
        vld_set    = 1'b1;
        vld_addr   = idx;
        res_load   = 1'b1;
        state_next = S_IDLE;
      end

      S_SW_RD: begin
        state_next = S_SW_EV;
      end

      S_SW_EV: begin
        if (valid[pos]) begin
          if ({cur.used, cur.modified} == 2'b00) begin
            // evict: valid flop cleared, ram contents masked from now on
            vld_clr    = 1'b1;
            res_load   = 1'b1;
            res_found  = 1'b1;
            res_index  = pos;
            res_frame  = cur.frame;
            res_dirty  = cur.dirty;
            hand_next  = pos_inc;
            state_next = S_IDLE;
          end else begin
            // age one step: 11 -> 10 -> 01 -> 00
            mem_we    = 1'b1;
            mem_wdata = cur;
            {mem_wdata.used, mem_wdata.modified} = {cur.used, cur.modified} - 2'd1;
            seen_next  = 1'b1;
            pos_next   = pos_inc;
            state_next = S_SW_RD;
          end
        end else begin
          pos_next = pos_inc;
          if (!seen && ({1'b0, cnt} == (swept - CNT_W'(1)))) begin
            // full rotation with nothing valid: no victim, hand untouched
            res_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            cnt_next   = cnt + IDX_W'(1);
            state_next = S_SW_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hand  <= '0;
    end else begin
      state <= state_next;
      hand  <= hand_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    cnt  <= cnt_next;
    seen <= seen_next;
    idx  <= idx_next;
    wr   <= wr_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      victim_found  <= res_found;
      victim_index  <= res_index;
      evicted_frame <= res_frame;
      victim_dirty  <= res_dirty;
    end
  end

endmodule

`default_nettype wire

/* hdl/capr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module capr_checker
  import capr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         mode,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               victim_found,
  input wire logic [IDX_W-1:0]   victim_index,
  input wire logic [FRAME_W-1:0] evicted_frame,
  input wire logic               victim_dirty
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(victim_found) &&
      $stable(victim_index) && $stable(evicted_frame) && $stable(victim_dirty))
    else $error("result changed while stalled");

  // no victim means an all-zero result
  a_zero_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !victim_found |-> victim_index == '0 && evicted_frame == '0 && !victim_dirty)
    else $error("non-zero fields without a victim");

  // a fill answers in the next cycle and never reports a victim
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && mode == MODE_FILL |=> out_valid && !victim_found)
    else $error("fill result missing");

  // nothing pending straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind clock_aging_page_replacement capr_checker u_capr_checker (.*);

`default_nettype wire
